[hdl/iocl_pkg.sv]
// Package for the in-order completion logger.
// Holds the transaction payload types, the controller state type and the
// command and status structs. Depends on nothing.
package iocl_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Input transaction payload.
  typedef struct packed {
    logic        op;
    logic [7:0]  task_id;
    logic [31:0] timestamp;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0]  task_id_res;
    logic [31:0] duration;
    logic        last;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RECORD,
    ST_RETIRE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the accepted transaction, read the id map
    logic do_start;    // allocate the tail entry
    logic record;      // store the duration of a younger entry, mark it done
    logic emit;        // retire the head entry into the output register
    logic rd_at_head;  // entry read address follows the head pointer
    logic first;       // the head entry is the one named by the end event
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;    // latched transaction is a start
    logic start_ok;    // start may allocate (in range, not live, not full)
    logic end_known;   // end names a live id
    logic is_head;     // the named entry is the head
    logic slot_done;   // the named entry is already done
    logic out_free;    // output register can take a result this cycle
    logic last;        // the entry being retired is the final one of the run
  } status_t;

endpackage

[hdl/iocl_ctrl.sv]
// Controller state machine of the in-order completion logger.
// Sequences lookup, record and retire steps; uses iocl_pkg for the state,
// command and status types.
module iocl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  iocl_pkg::status_t st,
  output iocl_pkg::cmd_t    cmd
);

  iocl_pkg::state_t state_r, state_nxt;
  logic             first_r, first_nxt;

  // State and first-result flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iocl_pkg::ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  // The block takes a new transaction only between items.
  assign in_stall = (state_r != iocl_pkg::ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    case (state_r)
      iocl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = iocl_pkg::ST_LOOKUP;
        end
      end
      iocl_pkg::ST_LOOKUP: begin
        state_nxt = iocl_pkg::ST_IDLE;
        if (st.is_start) begin
          cmd.do_start = st.start_ok;
        end else if (st.end_known) begin
          if (st.is_head) begin
            state_nxt = iocl_pkg::ST_RETIRE;
            first_nxt = 1'b1;
          end else if (!st.slot_done) begin
            state_nxt = iocl_pkg::ST_RECORD;
          end
        end
      end
      iocl_pkg::ST_RECORD: begin
        cmd.record = 1'b1;
        state_nxt  = iocl_pkg::ST_IDLE;
      end
      iocl_pkg::ST_RETIRE: begin
        cmd.rd_at_head = 1'b1;
        cmd.first      = first_r;
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          first_nxt = 1'b0;
          if (st.last) begin
            state_nxt = iocl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = iocl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/iocl_dp.sv]
// Datapath of the in-order completion logger.
// Holds the entry memories, the id map, head and occupancy, and the output
// register; uses iocl_pkg for payload, command and status types.
module iocl_dp #(
  parameter int DEPTH    = 16,
  parameter int ID_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iocl_pkg::in_item_t  in_data,
  input  iocl_pkg::cmd_t      cmd,
  output iocl_pkg::status_t   st,
  input  logic                out_stall,
  output logic                out_valid,
  output iocl_pkg::out_item_t out_data
);

  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = SLOT_W + 1;
  localparam int MAP_DEPTH = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam bit ID_ALL    = (ID_COUNT >= 256);

  // Latched transaction.
  logic        op_r;
  logic [7:0]  id_r;
  logic [31:0] ts_r;

  // Buffer control state.
  logic [SLOT_W-1:0]    head_r;
  logic [OCC_W-1:0]     occ_r;
  logic [DEPTH-1:0]     done_r;
  logic [MAP_DEPTH-1:0] map_valid_r;

  // Memories and their read registers.
  logic [SLOT_W-1:0] map_slot_mem [MAP_DEPTH];
  logic [7:0]        entry_task_mem [DEPTH];
  logic [31:0]       entry_time_mem [DEPTH];
  logic [SLOT_W-1:0] map_slot_q;
  logic [7:0]        ent_task_q;
  logic [31:0]       ent_time_q;

  // Output register.
  logic                out_valid_r;
  iocl_pkg::out_item_t out_data_r;

  logic              id_in_range;
  logic              map_hit;
  logic [SLOT_W-1:0] head_next;
  logic [SUM_W-1:0]  tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] rd_addr;
  logic              time_we;
  logic [SLOT_W-1:0] time_wa;
  logic [31:0]       time_wd;
  logic [31:0]       dur;

  // Id range check and map lookup for the latched id.
  assign id_in_range = ID_ALL || (32'(id_r) < 32'(ID_COUNT));
  assign map_hit     = id_in_range && map_valid_r[id_r[MAP_AW-1:0]];

  // Ring pointer arithmetic.
  assign head_next = (head_r == SLOT_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(occ_r);
  assign tail      = (tail_sum >= SUM_W'(DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(DEPTH))
                                                 : SLOT_W'(tail_sum);

  // Status toward the controller.
  always_comb begin
    st.is_start  = (op_r == iocl_pkg::OP_START);
    st.start_ok  = id_in_range && !map_hit && (occ_r != OCC_W'(DEPTH));
    st.end_known = map_hit && (occ_r != '0);
    st.is_head   = (map_slot_q == head_r);
    st.slot_done = done_r[map_slot_q];
    st.out_free  = !out_valid_r || !out_stall;
    st.last      = (occ_r == OCC_W'(1)) || !done_r[head_next];
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_data.op;
      id_r <= in_data.task_id;
      ts_r <= in_data.timestamp;
    end
  end

  // Id-to-slot map memory: read at capture, written at allocation.
  always_ff @(posedge clk) begin
    if (cmd.do_start) begin
      map_slot_mem[id_r[MAP_AW-1:0]] <= tail;
    end
    if (cmd.capture) begin
      map_slot_q <= map_slot_mem[in_data.task_id[MAP_AW-1:0]];
    end
  end

  // Entry memories: one write port for each, read every cycle.
  assign rd_addr = cmd.rd_at_head ? (cmd.emit ? head_next : head_r) : map_slot_q;
  assign time_we = cmd.do_start || cmd.record;
  assign time_wa = cmd.record ? map_slot_q : tail;
  assign time_wd = cmd.record ? (ts_r - ent_time_q) : ts_r;

  always_ff @(posedge clk) begin
    if (cmd.do_start) begin
      entry_task_mem[tail] <= id_r;
    end
    if (time_we) begin
      entry_time_mem[time_wa] <= time_wd;
    end
    ent_task_q <= entry_task_mem[rd_addr];
    ent_time_q <= entry_time_mem[rd_addr];
  end

  // Head, occupancy, done flags and map valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      done_r      <= '0;
      map_valid_r <= '0;
    end else begin
      if (cmd.do_start) begin
        done_r[tail]                  <= 1'b0;
        map_valid_r[id_r[MAP_AW-1:0]] <= 1'b1;
        occ_r                         <= occ_r + 1'b1;
      end
      if (cmd.record) begin
        done_r[map_slot_q] <= 1'b1;
      end
      if (cmd.emit) begin
        done_r[head_r]                      <= 1'b0;
        map_valid_r[ent_task_q[MAP_AW-1:0]] <= 1'b0;
        head_r                              <= head_next;
        occ_r                               <= occ_r - 1'b1;
      end
    end
  end

  // The first result measures against the end time; later ones are stored.
  assign dur = cmd.first ? (ts_r - ent_time_q) : ent_time_q;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.task_id_res <= ent_task_q;
      out_data_r.duration    <= dur;
      out_data_r.last        <= st.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupancy never exceeds the buffer depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  // A retire never happens on an empty buffer.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (occ_r != '0))
    else $error("retire on empty buffer");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("output register overwritten while stalled");

  // Allocation never falls in the same cycle as a retirement or a record.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_start && (cmd.emit || cmd.record)))
    else $error("conflicting buffer updates");

endmodule

[hdl/in_order_completion_logger_top.sv]
// In-order completion logger: top level.
// Instantiates iocl_ctrl and iocl_dp; uses iocl_pkg for payload types.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries start and
// end events of tasks, each with an id and a timestamp. The result channel
// (out_valid, out_stall, out_data) carries one transaction per retired task:
// its id, its duration (end minus start, modulo 2^32) and a last flag on the
// final result caused by one input event. Results come out in start order.
// Throughput: one input transaction is handled at a time. A start passes
// the idle and lookup states; an end of a younger task also the record
// state unless already done; an end of the oldest task then stays in the
// retire state until its run ends, and the run reads one entry per cycle
// from the entry memory while the receiver does not stall. The first result
// of a retire run passes the lookup and retire states to the output register.
// Reset (rst_n low, synchronous) empties the buffer and the id map at once;
// no clearing pass is needed. If the receiver stalls, the waiting result
// holds in the output register and the retire run pauses, while in_stall
// stays high until the run ends; input between items is not blocked by a
// waiting result.
module in_order_completion_logger_top #(
  parameter int DEPTH    = 16,
  parameter int ID_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iocl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iocl_pkg::out_item_t out_data
);

  iocl_pkg::cmd_t    cmd;
  iocl_pkg::status_t st;

  // Controller.
  iocl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  iocl_dp #(
    .DEPTH    (DEPTH),
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
